>>> rtl/core/sdaq_pkg.sv
// Shared types and codes for the sorted deadline alarm queue.
// No dependencies; sdaq_store, sdaq_ctrl and the top level use it by scope.
`timescale 1ns / 1ps
`default_nettype none

package sdaq_pkg;

   localparam int CAPACITY_DEF = 16;
   // most alarms handed out by a single tick request
   localparam int MAX_FIRED    = 16;
   localparam int FIRE_W       = $clog2(MAX_FIRED + 1);

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_DELETE = 2'd1;
   localparam logic [1:0] ACT_TICK   = 2'd2;

   localparam logic [2:0] K_INSERTED  = 3'd0;
   localparam logic [2:0] K_UPDATED   = 3'd1;
   localparam logic [2:0] K_PAST      = 3'd2;
   localparam logic [2:0] K_FULL      = 3'd3;
   localparam logic [2:0] K_DELETED   = 3'd4;
   localparam logic [2:0] K_NOT_FOUND = 3'd5;
   localparam logic [2:0] K_FIRED     = 3'd6;
   localparam logic [2:0] K_TICK_DONE = 3'd7;

   typedef struct packed {
      logic [31:0] dl;
      logic [15:0] tag;
   } entry_type;

   typedef struct packed {
      logic      en;
      entry_type entry;
   } store_wr_type;

endpackage

`default_nettype wire

>>> rtl/core/sdaq_req_if.sv
// Request channel of the alarm queue: valid/ready plus the request fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sdaq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] deadline;
   logic [15:0] tag;
   logic [31:0] now;

   modport source (output valid, action, deadline, tag, now, input ready);
   modport sink   (input valid, action, deadline, tag, now, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sdaq_rsp_if.sv
// Response channel of the alarm queue: valid/ready plus the result fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sdaq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] alarm_deadline;
   logic [15:0] alarm_tag;
   logic [31:0] next_wait;
   logic        queue_empty;
   logic        last;

   modport source (output valid, kind, alarm_deadline, alarm_tag, next_wait,
                   queue_empty, last, input ready);
   modport sink   (input valid, kind, alarm_deadline, alarm_tag, next_wait,
                   queue_empty, last, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sdaq_store.sv
// Alarm table memory: one write port, one read port with registered data.
// Depends on sdaq_pkg for the entry types.
`timescale 1ns / 1ps
`default_nettype none

module sdaq_store #(
   parameter int CAPACITY = sdaq_pkg::CAPACITY_DEF,
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire                         clock,
   input  wire sdaq_pkg::store_wr_type wr,
   input  wire  [IDX_W-1:0]            wr_addr,
   input  wire  [IDX_W-1:0]            rd_addr,
   output sdaq_pkg::entry_type         rd_entry_ff
);

   sdaq_pkg::entry_type store_mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr_addr] <= wr.entry;
      end
      rd_entry_ff <= store_mem[rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/core/sdaq_ctrl.sv
// Sequencer of the alarm queue: walks the table through one shared comparator,
// shifting entries one per step, and holds the response register.
// Depends on sdaq_pkg, sdaq_req_if, sdaq_rsp_if; drives sdaq_store.
`timescale 1ns / 1ps
`default_nettype none

module sdaq_ctrl #(
   parameter int CAPACITY = sdaq_pkg::CAPACITY_DEF,
   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire                    clock,
   input  wire                    reset,
   sdaq_req_if.sink               req_if,
   sdaq_rsp_if.source             rsp_if,
   output sdaq_pkg::store_wr_type wr,
   output logic [IDX_W-1:0]       wr_addr,
   output logic [IDX_W-1:0]       rd_addr,
   input  wire sdaq_pkg::entry_type rd_entry
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_FIND_RD  = 4'd2;
   localparam logic [3:0] S_FIND_CMP = 4'd3;
   localparam logic [3:0] S_SHIFT_RD = 4'd4;
   localparam logic [3:0] S_SHIFT_OP = 4'd5;
   localparam logic [3:0] S_REM_RD   = 4'd6;
   localparam logic [3:0] S_REM_OP   = 4'd7;
   localparam logic [3:0] S_TICK     = 4'd8;
   localparam logic [3:0] S_EMIT     = 4'd9;

   logic [3:0]  state_ff, state_in, ret_ff, ret_in;
   logic [1:0]  act_ff, act_in;
   logic [31:0] dl_ff, dl_in, now_ff, now_in;
   logic [15:0] tag_ff, tag_in;
   logic [CNT_W-1:0] count_ff, count_in, idx_ff, idx_in;
   logic [sdaq_pkg::FIRE_W-1:0] fired_ff, fired_in;
   sdaq_pkg::entry_type head_ff, head_in;

   // pending result, loaded into the response register in S_EMIT
   logic [2:0]  okind_ff, okind_in;
   logic [31:0] odl_ff, odl_in;
   logic [15:0] otag_ff, otag_in;
   logic        olast_ff, olast_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic [31:0] rsp_dl_ff, rsp_dl_in, rsp_wait_ff, rsp_wait_in;
   logic [15:0] rsp_tag_ff, rsp_tag_in;
   logic        rsp_empty_ff, rsp_empty_in, rsp_last_ff, rsp_last_in;

   // shared comparator
   logic [31:0] cmp_a, cmp_b;
   logic        cmp_gt, cmp_eq;

   logic [CNT_W:0]   idx_next;
   logic [CNT_W-1:0] idx_prev;
   logic [31:0]      wait_val;

   always_comb begin
      if (state_ff == S_DISPATCH) begin
         cmp_a = dl_ff;
         cmp_b = now_ff;
      end else if (state_ff == S_TICK) begin
         cmp_a = head_ff.dl;
         cmp_b = now_ff;
      end else begin
         cmp_a = rd_entry.dl;
         cmp_b = dl_ff;
      end
      cmp_gt = cmp_a > cmp_b;
      cmp_eq = cmp_a == cmp_b;
   end

   assign idx_next = {1'b0, idx_ff} + {{CNT_W{1'b0}}, 1'b1};
   assign idx_prev = idx_ff - CNT_W'(1);

   always_comb begin
      if (count_ff == '0) begin
         wait_val = '0;
      end else if (head_ff.dl > now_ff) begin
         wait_val = head_ff.dl - now_ff;
      end else begin
         wait_val = 32'd1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      act_in       = act_ff;
      dl_in        = dl_ff;
      now_in       = now_ff;
      tag_in       = tag_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      fired_in     = fired_ff;
      head_in      = head_ff;
      okind_in     = okind_ff;
      odl_in       = odl_ff;
      otag_in      = otag_ff;
      olast_in     = olast_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_dl_in    = rsp_dl_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_wait_in  = rsp_wait_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_last_in  = rsp_last_ff;
      req_if.ready = 1'b0;
      wr.en        = 1'b0;
      wr.entry     = '{dl: dl_ff, tag: tag_ff};
      wr_addr      = idx_ff[IDX_W-1:0];
      rd_addr      = idx_ff[IDX_W-1:0];

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               act_in   = req_if.action;
               dl_in    = req_if.deadline;
               tag_in   = req_if.tag;
               now_in   = req_if.now;
               idx_in   = '0;
               fired_in = '0;
               ret_in   = S_IDLE;
               olast_in = 1'b1;
               // unused action code: dropped without a response
               if (req_if.action == sdaq_pkg::ACT_INSERT ||
                   req_if.action == sdaq_pkg::ACT_DELETE ||
                   req_if.action == sdaq_pkg::ACT_TICK) begin
                  state_in = S_DISPATCH;
               end
            end
         end
         S_DISPATCH: begin
            case (act_ff)
               sdaq_pkg::ACT_INSERT: begin
                  if (!cmp_gt) begin
                     okind_in = sdaq_pkg::K_PAST;
                     odl_in   = dl_ff;
                     otag_in  = '0;
                     state_in = S_EMIT;
                  end else begin
                     state_in = S_FIND_RD;
                  end
               end
               sdaq_pkg::ACT_DELETE: state_in = S_FIND_RD;
               default:              state_in = S_TICK;
            endcase
         end
         S_FIND_RD: begin
            if (idx_ff == count_ff) begin
               odl_in  = dl_ff;
               otag_in = '0;
               if (act_ff == sdaq_pkg::ACT_INSERT) begin
                  if (count_ff >= CNT_W'(CAPACITY)) begin
                     okind_in = sdaq_pkg::K_FULL;
                     state_in = S_EMIT;
                  end else begin
                     // idx already equals count: open slot at the tail
                     state_in = S_SHIFT_RD;
                  end
               end else begin
                  okind_in = sdaq_pkg::K_NOT_FOUND;
                  state_in = S_EMIT;
               end
            end else begin
               state_in = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            if (cmp_eq) begin
               odl_in = dl_ff;
               if (act_ff == sdaq_pkg::ACT_INSERT) begin
                  wr.en       = 1'b1;
                  wr.entry.dl = rd_entry.dl;
                  okind_in    = sdaq_pkg::K_UPDATED;
                  otag_in     = tag_ff;
                  state_in    = S_EMIT;
               end else begin
                  okind_in = sdaq_pkg::K_DELETED;
                  otag_in  = rd_entry.tag;
                  state_in = S_REM_RD;
               end
            end else begin
               idx_in   = idx_next[CNT_W-1:0];
               state_in = S_FIND_RD;
            end
         end
         S_SHIFT_RD: begin
            rd_addr = idx_prev[IDX_W-1:0];
            if (idx_ff == '0) begin
               wr.en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               okind_in = sdaq_pkg::K_INSERTED;
               otag_in  = tag_ff;
               state_in = S_EMIT;
            end else begin
               state_in = S_SHIFT_OP;
            end
         end
         S_SHIFT_OP: begin
            wr.en = 1'b1;
            if (cmp_gt) begin
               wr.entry = rd_entry;
               idx_in   = idx_prev;
               state_in = S_SHIFT_RD;
            end else begin
               count_in = count_ff + CNT_W'(1);
               okind_in = sdaq_pkg::K_INSERTED;
               otag_in  = tag_ff;
               state_in = S_EMIT;
            end
         end
         S_REM_RD: begin
            rd_addr = idx_next[IDX_W-1:0];
            if (idx_next >= {1'b0, count_ff}) begin
               count_in = count_ff - CNT_W'(1);
               state_in = S_EMIT;
            end else begin
               state_in = S_REM_OP;
            end
         end
         S_REM_OP: begin
            wr.en    = 1'b1;
            wr.entry = rd_entry;
            idx_in   = idx_next[CNT_W-1:0];
            state_in = S_REM_RD;
         end
         S_TICK: begin
            if (fired_ff < sdaq_pkg::FIRE_W'(sdaq_pkg::MAX_FIRED) &&
                count_ff != '0 && !cmp_gt) begin
               okind_in = sdaq_pkg::K_FIRED;
               odl_in   = head_ff.dl;
               otag_in  = head_ff.tag;
               olast_in = 1'b0;
               fired_in = fired_ff + sdaq_pkg::FIRE_W'(1);
               idx_in   = '0;
               ret_in   = S_TICK;
               state_in = S_REM_RD;
            end else begin
               okind_in = sdaq_pkg::K_TICK_DONE;
               odl_in   = (count_ff != '0) ? head_ff.dl : 32'd0;
               otag_in  = '0;
               olast_in = 1'b1;
               ret_in   = S_IDLE;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = okind_ff;
               rsp_dl_in    = odl_ff;
               rsp_tag_in   = otag_ff;
               rsp_wait_in  = wait_val;
               rsp_empty_in = (count_ff == '0);
               rsp_last_in  = olast_ff;
               state_in     = ret_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // keep a copy of the head entry for ticks and wait times
      if (wr.en && wr_addr == '0) begin
         head_in = wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         count_ff     <= '0;
         fired_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         count_ff     <= count_in;
         fired_ff     <= fired_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff       <= act_in;
      dl_ff        <= dl_in;
      now_ff       <= now_in;
      tag_ff       <= tag_in;
      idx_ff       <= idx_in;
      head_ff      <= head_in;
      okind_ff     <= okind_in;
      odl_ff       <= odl_in;
      otag_ff      <= otag_in;
      olast_ff     <= olast_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_dl_ff    <= rsp_dl_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_wait_ff  <= rsp_wait_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.kind           = rsp_kind_ff;
   assign rsp_if.alarm_deadline = rsp_dl_ff;
   assign rsp_if.alarm_tag      = rsp_tag_ff;
   assign rsp_if.next_wait      = rsp_wait_ff;
   assign rsp_if.queue_empty    = rsp_empty_ff;
   assign rsp_if.last           = rsp_last_ff;

endmodule

`default_nettype wire

>>> rtl/core/sorted_deadline_alarm_queue.sv
// Top level of the sorted deadline alarm queue: sequencer plus alarm table.
// Depends on sdaq_pkg, sdaq_req_if, sdaq_rsp_if, sdaq_store, sdaq_ctrl.
//
//   channel | dir | fields                                             | handshake
//   req_if  | in  | action, deadline, tag, now                         | valid/ready
//   rsp_if  | out | kind, alarm_deadline, alarm_tag, next_wait,        | valid/ready
//           |     | queue_empty, last                                  |
//
// One request at a time; each table step is a read, then a compare and write
// (the memory has one read port and one write port).
// Synchronous reset empties the table at once (count cleared), no sweep.
// A stalled response holds the sequencer in its emit step; the next request is
// taken while the last response of the previous one still waits.
`timescale 1ns / 1ps
`default_nettype none

module sorted_deadline_alarm_queue #(
   parameter int CAPACITY = sdaq_pkg::CAPACITY_DEF
) (
   input  wire        clock,
   input  wire        reset,
   sdaq_req_if.sink   req_if,
   sdaq_rsp_if.source rsp_if
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   sdaq_pkg::store_wr_type wr;
   sdaq_pkg::entry_type    rd_entry;
   logic [IDX_W-1:0]       wr_addr;
   logic [IDX_W-1:0]       rd_addr;

   sdaq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rsp_if   (rsp_if),
      .wr       (wr),
      .wr_addr  (wr_addr),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry)
   );

   sdaq_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock       (clock),
      .wr          (wr),
      .wr_addr     (wr_addr),
      .rd_addr     (rd_addr),
      .rd_entry_ff (rd_entry)
   );

endmodule

`default_nettype wire
